>>> rtl/gsds_pkg.sv
// Shared types and constants of the grid scalar diffusion stencil unit.
`timescale 1ns / 1ps

package gsds_pkg;

    // Fixed field widths.
    localparam int VALUE_BITS  = 16;
    localparam int ENTRY_BITS  = VALUE_BITS + 1;
    localparam int WEIGHT_BITS = 17;
    localparam int FRAC_BITS   = 16;
    localparam int ROW_BITS    = 12;
    localparam int ROWS_BITS   = 13;
    localparam int COLS_BITS   = 9;
    localparam int ROW_LIMIT   = 4096;
    localparam int ROUND_HALF  = 1 << (FRAC_BITS - 1);

    // Configuration port.
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 17;

    localparam logic [CFG_INDEX_BITS-1:0] REG_GRID_COLUMNS  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_GRID_ROWS     = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_KEEP_WEIGHT   = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPREAD_WEIGHT = 2'd3;

    // Input action codes.
    localparam logic ACT_CELL  = 1'b0;
    localparam logic ACT_FLUSH = 1'b1;

    // One input item.
    typedef struct packed {
        logic                  action;
        logic [VALUE_BITS-1:0] cell_value;
        logic                  is_liquid;
    } cell_in_t;

    // One result item.
    typedef struct packed {
        logic [VALUE_BITS-1:0] new_value;
        logic                  last_cell;
    } result_t;

    // Neighborhood of one result cell, handed from the line stores to the filter.
    typedef struct packed {
        logic                  center_liquid;
        logic [VALUE_BITS-1:0] center;
        logic [VALUE_BITS-1:0] right;
        logic [VALUE_BITS-1:0] up;
        logic [VALUE_BITS-1:0] down;
        logic                  col_zero;
        logic                  last;
    } tap_set_t;

endpackage

>>> rtl/grid_scalar_diffusion_stencil_unit.sv
// Top level of the grid scalar diffusion stencil unit: position tracking and line stores.
`timescale 1ns / 1ps
//
//  Channel   Ports                              Direction  Moves
//  s_        s_valid s_ready s_data (cell_in_t) in         one grid cell or one flush
//  m_        m_valid m_ready m_data (result_t)  out        one diffused cell
//  cfg_      cfg_wr_en cfg_index cfg_data       in         one register write
//
//  One item is taken per cycle unless a stalled output has filled the pipeline; a result
//  passes line store read, average, weight products and rounding into the output register.
//  The rate is set by the line stores, which serve the center, right and up taps together
//  through two read ports per bank while the incoming cell is written.
//  Reset clears positions and the pipeline; the line stores are not cleared, so there is
//  no clearing pass. A stalled output fills the pipeline's empty stages before s_ready drops.

module grid_scalar_diffusion_stencil_unit #(
    parameter int MAX_COLUMNS = 256
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  gsds_pkg::cell_in_t                    s_data,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output gsds_pkg::result_t                     m_data,
    input  logic                                  cfg_wr_en,
    input  logic [gsds_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [gsds_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

    localparam int COL_BITS = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int VB       = gsds_pkg::VALUE_BITS;
    localparam int EB       = gsds_pkg::ENTRY_BITS;
    localparam int RB       = gsds_pkg::ROW_BITS;

    // Configuration registers.
    logic [gsds_pkg::COLS_BITS-1:0]   grid_columns_reg;
    logic [gsds_pkg::ROWS_BITS-1:0]   grid_rows_reg;
    logic [gsds_pkg::WEIGHT_BITS-1:0] keep_weight_reg;
    logic [gsds_pkg::WEIGHT_BITS-1:0] spread_weight_reg;

    // Stream position.
    logic [COL_BITS-1:0] in_column_reg, in_column_next;
    logic [RB-1:0]       in_row_reg, in_row_next;
    logic [COL_BITS-1:0] out_column_reg, out_column_next;
    logic                grid_complete_reg, grid_complete_next;

    // Line store read stage.
    logic          s1_valid_reg, s1_valid_next;
    logic          s1_rb_reg;
    logic          s1_up_self_reg;
    logic          s1_down_self_reg;
    logic          s1_col_zero_reg;
    logic          s1_last_reg;
    logic [VB-1:0] s1_down_reg;

    logic [COL_BITS-1:0] last_col;
    logic [RB-1:0]       last_row;
    logic                accept;
    logic                cell_take;
    logic                flush_take;
    logic                size_write;
    logic                s1_en;
    logic                tap_ready;
    logic [COL_BITS-1:0] col_sel;
    logic [COL_BITS-1:0] col_right;
    logic                col_is_last;
    logic                rd_bank;
    logic [1:0]          bank_we;
    logic [EB-1:0]       entry;
    logic [EB-1:0]       rd_a [2];
    logic [EB-1:0]       rd_b [2];
    logic [EB-1:0]       center_word;
    logic [EB-1:0]       right_word;
    logic [EB-1:0]       up_word;
    gsds_pkg::tap_set_t  taps;

    // Effective grid size with out-of-range settings clamped.
    always_comb begin
        if (grid_columns_reg == '0) begin
            last_col = '0;
        end else if (32'(grid_columns_reg) > MAX_COLUMNS) begin
            last_col = COL_BITS'(MAX_COLUMNS - 1);
        end else begin
            last_col = COL_BITS'(grid_columns_reg - 1'b1);
        end
        if (grid_rows_reg == '0) begin
            last_row = '0;
        end else if (32'(grid_rows_reg) > gsds_pkg::ROW_LIMIT) begin
            last_row = RB'(gsds_pkg::ROW_LIMIT - 1);
        end else begin
            last_row = RB'(grid_rows_reg - 1'b1);
        end
    end

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_columns_reg  <= gsds_pkg::COLS_BITS'(256);
            grid_rows_reg     <= gsds_pkg::ROWS_BITS'(256);
            keep_weight_reg   <= gsds_pkg::WEIGHT_BITS'(65536);
            spread_weight_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                gsds_pkg::REG_GRID_COLUMNS: begin
                    grid_columns_reg <= cfg_data[gsds_pkg::COLS_BITS-1:0];
                end
                gsds_pkg::REG_GRID_ROWS: begin
                    grid_rows_reg <= cfg_data[gsds_pkg::ROWS_BITS-1:0];
                end
                gsds_pkg::REG_KEEP_WEIGHT: begin
                    keep_weight_reg <= cfg_data;
                end
                gsds_pkg::REG_SPREAD_WEIGHT: begin
                    spread_weight_reg <= cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // Transfer decode. Cells after a complete grid and early flushes are taken and dropped.
    assign s1_en      = !s1_valid_reg || tap_ready;
    assign s_ready    = s1_en;
    assign accept     = s_valid && s_ready;
    assign cell_take  = accept && (s_data.action == gsds_pkg::ACT_CELL) && !grid_complete_reg;
    assign flush_take = accept && (s_data.action == gsds_pkg::ACT_FLUSH) && grid_complete_reg;
    assign size_write = cfg_wr_en && ((cfg_index == gsds_pkg::REG_GRID_COLUMNS)
                                   || (cfg_index == gsds_pkg::REG_GRID_ROWS));

    // Line store addressing: the result's row sits in the bank not being written.
    assign col_sel     = grid_complete_reg ? out_column_reg : in_column_reg;
    assign col_is_last = (col_sel == last_col);
    assign col_right   = col_is_last ? col_sel : col_sel + 1'b1;
    assign rd_bank     = grid_complete_reg ? in_row_reg[0] : ~in_row_reg[0];
    assign bank_we[0]  = cell_take && !in_row_reg[0];
    assign bank_we[1]  = cell_take && in_row_reg[0];
    assign entry       = {s_data.is_liquid, s_data.cell_value};

    // Position counters and read stage valid.
    always_comb begin
        in_column_next     = in_column_reg;
        in_row_next        = in_row_reg;
        out_column_next    = out_column_reg;
        grid_complete_next = grid_complete_reg;
        s1_valid_next      = s1_valid_reg;
        if (s1_en) begin
            s1_valid_next = (cell_take && (in_row_reg != '0)) || flush_take;
        end
        if (cell_take) begin
            if (col_is_last) begin
                in_column_next = '0;
                if (in_row_reg == last_row) begin
                    grid_complete_next = 1'b1;
                    out_column_next    = '0;
                end else begin
                    in_row_next = in_row_reg + 1'b1;
                end
            end else begin
                in_column_next = in_column_reg + 1'b1;
            end
        end
        if (flush_take) begin
            if (col_is_last) begin
                in_column_next     = '0;
                in_row_next        = '0;
                out_column_next    = '0;
                grid_complete_next = 1'b0;
            end else begin
                out_column_next = out_column_reg + 1'b1;
            end
        end
        if (size_write) begin
            in_column_next     = '0;
            in_row_next        = '0;
            out_column_next    = '0;
            grid_complete_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_column_reg     <= '0;
            in_row_reg        <= '0;
            out_column_reg    <= '0;
            grid_complete_reg <= 1'b0;
            s1_valid_reg      <= 1'b0;
        end else begin
            in_column_reg     <= in_column_next;
            in_row_reg        <= in_row_next;
            out_column_reg    <= out_column_next;
            grid_complete_reg <= grid_complete_next;
            s1_valid_reg      <= s1_valid_next;
        end
    end

    // Side information that travels with the line store read.
    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_rb_reg        <= rd_bank;
            s1_up_self_reg   <= grid_complete_reg ? (in_row_reg == '0)
                                                  : (in_row_reg == RB'(1));
            s1_down_self_reg <= grid_complete_reg;
            s1_col_zero_reg  <= (col_sel == '0);
            s1_last_reg      <= grid_complete_reg && col_is_last;
            s1_down_reg      <= s_data.cell_value;
        end
    end

    // Two line store banks, chosen by row parity.
    for (genvar k = 0; k < 2; k++) begin : g_bank
        gsds_line_bank #(
            .DEPTH     (MAX_COLUMNS),
            .ADDR_BITS (COL_BITS)
        ) u_bank (
            .aclk      (aclk),
            .wr_en     (bank_we[k]),
            .wr_addr   (in_column_reg),
            .wr_data   (entry),
            .rd_en     (accept),
            .rd_addr_a (col_sel),
            .rd_addr_b (col_right),
            .rd_data_a (rd_a[k]),
            .rd_data_b (rd_b[k])
        );
    end

    // Tap selection; at the top and bottom edges the center stands in for the missing row.
    assign center_word = s1_rb_reg ? rd_a[1] : rd_a[0];
    assign right_word  = s1_rb_reg ? rd_b[1] : rd_b[0];
    assign up_word     = s1_rb_reg ? rd_a[0] : rd_a[1];

    always_comb begin
        taps.center_liquid = center_word[VB];
        taps.center        = center_word[VB-1:0];
        taps.right         = right_word[VB-1:0];
        taps.up            = s1_up_self_reg ? center_word[VB-1:0] : up_word[VB-1:0];
        taps.down          = s1_down_self_reg ? center_word[VB-1:0] : s1_down_reg;
        taps.col_zero      = s1_col_zero_reg;
        taps.last          = s1_last_reg;
    end

    gsds_filter u_filter (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .tap_valid     (s1_valid_reg),
        .tap_ready     (tap_ready),
        .taps          (taps),
        .keep_weight   (keep_weight_reg),
        .spread_weight (spread_weight_reg),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data)
    );

    // A complete grid waits at the start of a row.
    a_complete_col_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        grid_complete_reg |-> (in_column_reg == '0))
        else $error("input column not at zero while the grid is complete");

    // No line store write once the grid is complete.
    a_no_write_complete: assert property (@(posedge aclk) disable iff (!aresetn)
        grid_complete_reg |-> (bank_we == 2'b00))
        else $error("line store written after the grid was complete");

    // A flush of a complete grid always produces a result in the read stage.
    a_flush_reads: assert property (@(posedge aclk) disable iff (!aresetn)
        (flush_take && !size_write) |=> s1_valid_reg)
        else $error("flush of a complete grid produced no read stage entry");

    // Only the final flush of a grid is marked as the last cell.
    a_last_from_flush: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && s1_last_reg) |-> s1_down_self_reg)
        else $error("last cell marked on a result caused by a grid cell");

endmodule

>>> rtl/gsds_line_bank.sv
// One line store bank: one write port and two registered read ports.
`timescale 1ns / 1ps

module gsds_line_bank #(
    parameter int DEPTH     = 256,
    parameter int ADDR_BITS = 8
) (
    input  logic                             aclk,
    input  logic                             wr_en,
    input  logic [ADDR_BITS-1:0]             wr_addr,
    input  logic [gsds_pkg::ENTRY_BITS-1:0]  wr_data,
    input  logic                             rd_en,
    input  logic [ADDR_BITS-1:0]             rd_addr_a,
    input  logic [ADDR_BITS-1:0]             rd_addr_b,
    output logic [gsds_pkg::ENTRY_BITS-1:0]  rd_data_a,
    output logic [gsds_pkg::ENTRY_BITS-1:0]  rd_data_b
);

    logic [gsds_pkg::ENTRY_BITS-1:0] store_mem [DEPTH];
    logic [gsds_pkg::ENTRY_BITS-1:0] rd_data_a_reg;
    logic [gsds_pkg::ENTRY_BITS-1:0] rd_data_b_reg;

    // Reads return the old contents when the same entry is written in the same cycle.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_a_reg <= store_mem[rd_addr_a];
            rd_data_b_reg <= store_mem[rd_addr_b];
        end
    end

    assign rd_data_a = rd_data_a_reg;
    assign rd_data_b = rd_data_b_reg;

endmodule

>>> rtl/gsds_filter.sv
// Averaging, weighting, rounding and output register of the stencil.
`timescale 1ns / 1ps

module gsds_filter (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               tap_valid,
    output logic                               tap_ready,
    input  gsds_pkg::tap_set_t                 taps,
    input  logic [gsds_pkg::WEIGHT_BITS-1:0]   keep_weight,
    input  logic [gsds_pkg::WEIGHT_BITS-1:0]   spread_weight,
    output logic                               m_valid,
    input  logic                               m_ready,
    output gsds_pkg::result_t                  m_data
);

    localparam int VB        = gsds_pkg::VALUE_BITS;
    localparam int SUM_BITS  = VB + 2;
    localparam int PROD_BITS = gsds_pkg::WEIGHT_BITS + VB;
    localparam int ACC_BITS  = PROD_BITS + 1;
    localparam int SCL_BITS  = ACC_BITS - gsds_pkg::FRAC_BITS;

    // Stage enables: a stage moves when it is empty or its successor moves.
    logic out_en;
    logic s3_en;
    logic s2_en;

    logic            s2_valid_reg;
    logic [VB-1:0]   s2_value_reg;
    logic            s2_liquid_reg;
    logic [VB-1:0]   s2_avg_reg;
    logic            s2_last_reg;
    logic [VB-1:0]   prev_center_reg;

    logic                 s3_valid_reg;
    logic [PROD_BITS-1:0] s3_keep_prod_reg;
    logic [PROD_BITS-1:0] s3_spread_prod_reg;
    logic [VB-1:0]        s3_value_reg;
    logic                 s3_liquid_reg;
    logic                 s3_last_reg;

    logic              out_valid_reg;
    gsds_pkg::result_t out_data_reg;
    gsds_pkg::result_t out_data_next;

    logic [VB-1:0]       left_value;
    logic [SUM_BITS-1:0] nb_sum;
    logic [ACC_BITS-1:0] acc_sum;
    logic [SCL_BITS-1:0] scaled;

    assign out_en    = !out_valid_reg || m_ready;
    assign s3_en     = !s3_valid_reg || out_en;
    assign s2_en     = !s2_valid_reg || s3_en;
    assign tap_ready = s2_en;

    // The left neighbor is the previous result's center, or the center itself at column zero.
    assign left_value = taps.col_zero ? taps.center : prev_center_reg;
    assign nb_sum     = SUM_BITS'(left_value) + SUM_BITS'(taps.right)
                      + SUM_BITS'(taps.up) + SUM_BITS'(taps.down);

    // Stage 2: neighbor average.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (s2_en) begin
            s2_valid_reg <= tap_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_en && tap_valid) begin
            s2_value_reg    <= taps.center;
            s2_liquid_reg   <= taps.center_liquid;
            s2_avg_reg      <= nb_sum[SUM_BITS-1:2];
            s2_last_reg     <= taps.last;
            prev_center_reg <= taps.center;
        end
    end

    // Stage 3: the two weight products.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
        end else if (s3_en) begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s3_en && s2_valid_reg) begin
            s3_keep_prod_reg   <= PROD_BITS'(keep_weight) * PROD_BITS'(s2_value_reg);
            s3_spread_prod_reg <= PROD_BITS'(spread_weight) * PROD_BITS'(s2_avg_reg);
            s3_value_reg       <= s2_value_reg;
            s3_liquid_reg      <= s2_liquid_reg;
            s3_last_reg        <= s2_last_reg;
        end
    end

    // Output stage: round, scale back, saturate; dry cells pass unchanged.
    assign acc_sum = ACC_BITS'(s3_keep_prod_reg) + ACC_BITS'(s3_spread_prod_reg)
                   + ACC_BITS'(gsds_pkg::ROUND_HALF);
    assign scaled  = acc_sum[ACC_BITS-1:gsds_pkg::FRAC_BITS];

    always_comb begin
        out_data_next.last_cell = s3_last_reg;
        if (!s3_liquid_reg) begin
            out_data_next.new_value = s3_value_reg;
        end else if (|scaled[SCL_BITS-1:VB]) begin
            out_data_next.new_value = '1;
        end else begin
            out_data_next.new_value = scaled[VB-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_en) begin
            out_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_en && s3_valid_reg) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

>>> tb/sv/grid_scalar_diffusion_stencil_checker.sv
// Checker for the grid scalar diffusion stencil unit: predicts results and compares them.
`timescale 1ns / 1ps

module grid_scalar_diffusion_stencil_checker #(
    parameter int MAX_COLUMNS = 256
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    input  logic                                s_ready,
    input  gsds_pkg::cell_in_t                  s_data,
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  gsds_pkg::result_t                   m_data,
    input  logic                                cfg_wr_en,
    input  logic [gsds_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [gsds_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    output int                                  error_count,
    output int                                  pending_results
);

    localparam int VB = gsds_pkg::VALUE_BITS;
    localparam int EB = gsds_pkg::ENTRY_BITS;

    // Two banks of earlier rows, value plus liquid flag, chosen by row parity.
    logic [EB-1:0] line_bank [0:2*MAX_COLUMNS-1];

    // Shadow copy of the configuration registers.
    logic [gsds_pkg::COLS_BITS-1:0]   grid_columns;
    logic [gsds_pkg::ROWS_BITS-1:0]   grid_rows;
    logic [gsds_pkg::WEIGHT_BITS-1:0] keep_weight;
    logic [gsds_pkg::WEIGHT_BITS-1:0] spread_weight;

    // Stream position of the next input cell and of the next flushed result.
    int unsigned in_col;
    int unsigned in_row;
    int unsigned out_col;
    int unsigned out_row;
    bit          grid_received;

    gsds_pkg::result_t diffused_q[$];
    int                mismatches = 0;

    initial begin
        foreach (line_bank[i]) line_bank[i] = '0;
    end

    function automatic int unsigned used_columns();
        if (grid_columns == 0) return 1;
        if (grid_columns > MAX_COLUMNS) return MAX_COLUMNS;
        return grid_columns;
    endfunction

    function automatic int unsigned used_rows();
        if (grid_rows == 0) return 1;
        if (grid_rows > gsds_pkg::ROW_LIMIT) return gsds_pkg::ROW_LIMIT;
        return grid_rows;
    endfunction

    function automatic logic [EB-1:0] bank_entry(int unsigned bank, int unsigned col);
        return line_bank[(bank % 2) * MAX_COLUMNS + (col % MAX_COLUMNS)];
    endfunction

    // Diffused value of one cell of the row in the given bank, with its vertical neighbors.
    function automatic logic [VB-1:0] diffuse_cell(int unsigned bank, int unsigned col,
                                                   logic [VB-1:0] up,
                                                   logic [VB-1:0] down);
        logic [EB-1:0]   center;
        logic [EB-1:0]   left_entry;
        logic [EB-1:0]   right_entry;
        int unsigned     cols;
        logic [VB+1:0]   neighbor_sum;
        logic [63:0]     acc;
        logic [63:0]     value_max;

        cols        = used_columns();
        center      = bank_entry(bank, col);
        left_entry  = bank_entry(bank, (col > 0) ? col - 1 : 0);
        right_entry = bank_entry(bank, (col + 1 < cols) ? col + 1 : cols - 1);
        value_max   = (64'd1 << VB) - 1;

        // Dry cells keep their value; wet neighbors of dry cells still average them in.
        if (!center[VB]) return center[VB-1:0];

        neighbor_sum = (VB+2)'(left_entry[VB-1:0])
                     + (VB+2)'(right_entry[VB-1:0])
                     + (VB+2)'(up) + (VB+2)'(down);
        acc = 64'(keep_weight) * 64'(center[VB-1:0])
            + 64'(spread_weight) * 64'(neighbor_sum >> 2) + 64'(gsds_pkg::ROUND_HALF);
        acc = acc >> gsds_pkg::FRAC_BITS;
        return (acc > value_max) ? '1 : acc[VB-1:0];
    endfunction

    task automatic restart_stream();
        in_col        = 0;
        in_row        = 0;
        out_col       = 0;
        out_row       = 0;
        grid_received = 1'b0;
    endtask

    // A cell of row r+1 completes the neighborhood of the cell above it in row r.
    task automatic accept_cell(input gsds_pkg::cell_in_t item);
        logic [EB-1:0]     up_entry;
        int unsigned       col;
        int unsigned       bank;
        int unsigned       prev_bank;
        gsds_pkg::result_t predicted;

        if (grid_received) return;
        col  = in_col % MAX_COLUMNS;
        bank = in_row % 2;
        if (in_row >= 1) begin
            prev_bank = (in_row - 1) % 2;
            up_entry  = (in_row >= 2) ? bank_entry(bank, col) : bank_entry(prev_bank, col);
            predicted.new_value = diffuse_cell(prev_bank, col, up_entry[VB-1:0],
                                               item.cell_value);
            predicted.last_cell = 1'b0;
            diffused_q.insert(diffused_q.size(), predicted);
        end
        line_bank[bank * MAX_COLUMNS + col] = {item.is_liquid, item.cell_value};
        out_col = col;
        out_row = in_row;

        if (in_col + 1 >= used_columns()) begin
            in_col = 0;
            if (in_row + 1 >= used_rows()) begin
                grid_received = 1'b1;
                out_col       = 0;
                out_row       = in_row;
            end else begin
                in_row++;
            end
        end else begin
            in_col++;
        end
    endtask

    // Each flush emits one cell of the last row; its bottom neighbor is itself.
    task automatic accept_flush();
        logic [EB-1:0]     center_entry;
        logic [EB-1:0]     up_entry;
        int unsigned       col;
        int unsigned       bank;
        gsds_pkg::result_t predicted;

        if (!grid_received) return;
        col          = out_col % MAX_COLUMNS;
        bank         = out_row % 2;
        center_entry = bank_entry(bank, col);
        up_entry     = (out_row >= 1) ? bank_entry(bank ^ 1, col) : center_entry;
        predicted.new_value = diffuse_cell(bank, col, up_entry[VB-1:0],
                                           center_entry[VB-1:0]);
        if (out_col + 1 >= used_columns()) begin
            predicted.last_cell = 1'b1;
            restart_stream();
        end else begin
            predicted.last_cell = 1'b0;
            out_col++;
        end
        diffused_q.insert(diffused_q.size(), predicted);
    endtask

    // Track register writes and input transfers, then check each result transfer.
    always @(posedge aclk) begin : watch
        gsds_pkg::result_t oldest;

        if (!aresetn) begin
            grid_columns  = 9'd256;
            grid_rows     = 13'd256;
            keep_weight   = 17'd65536;
            spread_weight = 17'd0;
            restart_stream();
            diffused_q.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    gsds_pkg::REG_GRID_COLUMNS: begin
                        grid_columns = cfg_data[gsds_pkg::COLS_BITS-1:0];
                        restart_stream();
                        diffused_q.delete();
                    end
                    gsds_pkg::REG_GRID_ROWS: begin
                        grid_rows = cfg_data[gsds_pkg::ROWS_BITS-1:0];
                        restart_stream();
                        diffused_q.delete();
                    end
                    gsds_pkg::REG_KEEP_WEIGHT: begin
                        keep_weight = cfg_data[gsds_pkg::WEIGHT_BITS-1:0];
                    end
                    gsds_pkg::REG_SPREAD_WEIGHT: begin
                        spread_weight = cfg_data[gsds_pkg::WEIGHT_BITS-1:0];
                    end
                    default: ;
                endcase
            end

            if (s_valid && s_ready) begin
                if (s_data.action == gsds_pkg::ACT_CELL) accept_cell(s_data);
                else accept_flush();
            end

            if (m_valid && m_ready) begin
                if (diffused_q.size() == 0) begin
                    $display("%0t: unexpected result: expected none, %s %0d last_cell %0b",
                             $time, "got new_value", m_data.new_value, m_data.last_cell);
                    mismatches++;
                end else begin
                    oldest = diffused_q.pop_front();
                    if (m_data.new_value !== oldest.new_value) begin
                        $display("%0t: new_value mismatch: expected %0d, got %0d",
                                 $time, oldest.new_value, m_data.new_value);
                        mismatches++;
                    end
                    if (m_data.last_cell !== oldest.last_cell) begin
                        $display("%0t: last_cell mismatch: expected %0b, got %0b",
                                 $time, oldest.last_cell, m_data.last_cell);
                        mismatches++;
                    end
                end
            end
        end
        pending_results <= diffused_q.size();
        error_count     <= mismatches;
    end

endmodule

>>> tb/sv/grid_scalar_diffusion_stencil_unit_test.sv
// Top of the stencil unit testbench: clock, reset, stimulus, watchdog and verdict.
`timescale 1ns / 1ps

module grid_scalar_diffusion_stencil_unit_test;

    localparam int MAX_COLUMNS     = 256;
    localparam int QUIET_LIMIT     = 2000;
    localparam int SETTLE_CYCLES   = 8;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int PHASE_ITEMS     = 90;
    localparam int VB              = gsds_pkg::VALUE_BITS;
    localparam int WB              = gsds_pkg::WEIGHT_BITS;

    logic                                aclk;
    logic                                aresetn;
    logic                                s_valid;
    logic                                s_ready;
    gsds_pkg::cell_in_t                  s_data;
    logic                                m_valid;
    logic                                m_ready;
    gsds_pkg::result_t                   m_data;
    logic                                cfg_wr_en;
    logic [gsds_pkg::CFG_INDEX_BITS-1:0] cfg_index;
    logic [gsds_pkg::CFG_DATA_BITS-1:0]  cfg_data;

    int          error_count;
    int          pending_results;
    int          tx_idle_pct     = 38;
    int          rx_idle_pct     = 84;
    bit          hold_off_request = 1'b0;
    int          quiet_cycles    = 0;
    int          item_count      = 0;
    int unsigned active_cols     = 256;
    int unsigned active_rows     = 256;
    bit          grid_cut        = 1'b0;

    grid_scalar_diffusion_stencil_unit #(
        .MAX_COLUMNS(MAX_COLUMNS)
    ) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    grid_scalar_diffusion_stencil_checker #(
        .MAX_COLUMNS(MAX_COLUMNS)
    ) diffusion_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data          (s_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .error_count     (error_count),
        .pending_results (pending_results)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Result side: random back-pressure, plus one long hold-off when requested.
    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_off_request) begin
                hold_off_request = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
            end
            m_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // End the run if no transfer happens on either channel for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Offer one item after a random gap and hold it until the transfer.
    task automatic send_item(input gsds_pkg::cell_in_t item);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic send_cell(input logic [VB-1:0] value, input logic liquid);
        gsds_pkg::cell_in_t item;
        item.action     = gsds_pkg::ACT_CELL;
        item.cell_value = value;
        item.is_liquid  = liquid;
        send_item(item);
    endtask

    // Value and flag of a flush carry no meaning, so they are random.
    task automatic send_flush();
        gsds_pkg::cell_in_t item;
        item.action     = gsds_pkg::ACT_FLUSH;
        item.cell_value = VB'($urandom);
        item.is_liquid  = 1'($urandom);
        send_item(item);
    endtask

    function automatic logic [VB-1:0] pick_value();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return VB'($urandom_range(0, 15));
            default: return VB'($urandom);
        endcase
    endfunction

    task automatic pick_weights(output logic [WB-1:0] keep,
                                output logic [WB-1:0] spread);
        case ($urandom_range(0, 5))
            0: begin
                keep   = 17'd65536;
                spread = 17'd0;
            end
            1: begin
                keep   = 17'd0;
                spread = 17'd65536;
            end
            2: begin
                // Random weights may sum above one and drive the saturation path.
                keep   = WB'($urandom);
                spread = WB'($urandom);
            end
            default: begin
                spread = WB'($urandom_range(0, 65536));
                keep   = 17'd65536 - spread;
            end
        endcase
    endtask

    // One register write; the caller lowers the write enable after its last write.
    task automatic write_reg(input logic [gsds_pkg::CFG_INDEX_BITS-1:0] index,
                             input logic [gsds_pkg::CFG_DATA_BITS-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge aclk);
    endtask

    task automatic set_weights(input logic [WB-1:0] keep,
                               input logic [WB-1:0] spread);
        write_reg(gsds_pkg::REG_KEEP_WEIGHT, keep);
        write_reg(gsds_pkg::REG_SPREAD_WEIGHT, spread);
        cfg_wr_en <= 1'b0;
    endtask

    // Full setup; unused upper data bits carry random junk the block must ignore.
    task automatic configure(input logic [gsds_pkg::COLS_BITS-1:0] cols_raw,
                             input logic [gsds_pkg::ROWS_BITS-1:0] rows_raw,
                             input logic [WB-1:0] keep,
                             input logic [WB-1:0] spread);
        write_reg(gsds_pkg::REG_KEEP_WEIGHT, keep);
        write_reg(gsds_pkg::REG_SPREAD_WEIGHT, spread);
        write_reg(gsds_pkg::REG_GRID_COLUMNS, {8'($urandom), cols_raw});
        write_reg(gsds_pkg::REG_GRID_ROWS, {4'($urandom), rows_raw});
        cfg_wr_en <= 1'b0;
        active_cols = (cols_raw == 0) ? 1 : (cols_raw > MAX_COLUMNS) ? MAX_COLUMNS : cols_raw;
        active_rows = (rows_raw == 0) ? 1
                    : (rows_raw > gsds_pkg::ROW_LIMIT) ? gsds_pkg::ROW_LIMIT : rows_raw;
    endtask

    // Stop offering, wait for every predicted result, then let the pipeline settle.
    task automatic drain();
        s_valid <= 1'b0;
        repeat (2) @(posedge aclk);
        while (pending_results != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Stream one grid and its flushes, with optional ignored items, an early cut
    // that leaves the grid unfinished, and a weight change part way through.
    task automatic run_grid(input int unsigned cols, input int unsigned rows,
                            input bit noisy, input bit may_cut);
        int unsigned total;
        int unsigned cut_at;
        int unsigned reweight_at;
        logic [WB-1:0] keep;
        logic [WB-1:0] spread;

        total       = cols * rows;
        cut_at      = (may_cut && $urandom_range(0, 9) == 0)
                    ? $urandom_range(0, total - 1) : total;
        reweight_at = (noisy && $urandom_range(0, 5) == 0)
                    ? $urandom_range(0, total - 1) : total;
        grid_cut    = 1'b0;

        for (int unsigned n = 0; n < total; n++) begin
            if (n == cut_at) begin
                grid_cut = 1'b1;
                drain();
                return;
            end
            if (n == reweight_at) begin
                drain();
                pick_weights(keep, spread);
                set_weights(keep, spread);
            end
            if (noisy && $urandom_range(0, 29) == 0) send_flush();
            send_cell(pick_value(), $urandom_range(0, 3) != 0);
            item_count++;
        end
        if (noisy && $urandom_range(0, 3) == 0) send_cell(pick_value(), 1'($urandom));
        repeat (cols) begin
            send_flush();
            item_count++;
        end
    endtask

    // Mostly small grids; a grid either reuses the running setup or gets a new one.
    task automatic random_grid();
        logic [gsds_pkg::COLS_BITS-1:0] cols_raw;
        logic [gsds_pkg::ROWS_BITS-1:0] rows_raw;
        logic [WB-1:0]                  keep;
        logic [WB-1:0]                  spread;

        if (grid_cut || $urandom_range(0, 9) < 7) begin
            case ($urandom_range(0, 19))
                0:       cols_raw = '0;
                1:       cols_raw = gsds_pkg::COLS_BITS'($urandom_range(13, 48));
                default: cols_raw = gsds_pkg::COLS_BITS'($urandom_range(1, 10));
            endcase
            rows_raw = ($urandom_range(0, 9) == 0) ? '0
                     : gsds_pkg::ROWS_BITS'($urandom_range(1, 6));
            pick_weights(keep, spread);
            drain();
            configure(cols_raw, rows_raw, keep, spread);
        end
        run_grid(active_cols, active_rows, 1'b1, 1'b1);
    endtask

    initial begin
        int target;
        logic [WB-1:0] keep;
        logic [WB-1:0] spread;

        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_data    <= '0;
        cfg_wr_en <= 1'b0;
        cfg_index <= gsds_pkg::REG_GRID_COLUMNS;
        cfg_data  <= '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset setup: 256-wide rows with pass-through weights, cut short four cells into row 1.
        repeat (MAX_COLUMNS + 4) send_cell(pick_value(), $urandom_range(0, 3) != 0);
        drain();

        // Three-by-two grid: flush too early, extreme values, dry cells, cell after the end.
        configure(9'd3, 13'd2, 17'd49152, 17'd16384);
        send_flush();
        send_cell(16'd0, 1'b1);
        send_cell(16'hFFFF, 1'b1);
        send_cell(16'd1, 1'b0);
        send_cell(16'h8000, 1'b1);
        send_cell(16'hFFFF, 1'b0);
        send_cell(16'd0, 1'b1);
        send_cell(16'h1234, 1'b1);
        repeat (3) send_flush();
        drain();

        // Zero sizes act as one cell; full weights on both terms saturate.
        configure(9'd0, 13'd0, 17'd65536, 17'd65536);
        send_cell(16'hFFFF, 1'b1);
        send_flush();
        drain();

        // Single column, zero own weight, largest spread field value.
        configure(9'd1, 13'd3, 17'd0, 17'h1FFFF);
        send_cell(16'hFFFF, 1'b1);
        send_cell(16'h8000, 1'b1);
        send_cell(16'd0, 1'b1);
        send_flush();
        drain();

        // Single row, largest own weight field value.
        configure(9'd2, 13'd1, 17'h1FFFF, 17'd0);
        send_cell(16'hFFFF, 1'b1);
        send_cell(16'h7FFF, 1'b1);
        repeat (2) send_flush();
        drain();

        // Sender idles often, receiver very often.
        target = item_count + PHASE_ITEMS;
        while (item_count < target) random_grid();

        // Receiver idles often, sender very often; one over-wide single-row grid.
        tx_idle_pct = 84;
        rx_idle_pct = 38;
        drain();
        pick_weights(keep, spread);
        configure(gsds_pkg::COLS_BITS'($urandom_range(MAX_COLUMNS + 1, 511)), 13'd1,
                  keep, spread);
        run_grid(active_cols, active_rows, 1'b1, 1'b0);
        target = item_count + PHASE_ITEMS;
        while (item_count < target) random_grid();

        // No idling; a long receiver hold-off while a larger grid streams in.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        drain();
        pick_weights(keep, spread);
        configure(9'd8, 13'd6, keep, spread);
        hold_off_request = 1'b1;
        run_grid(active_cols, active_rows, 1'b0, 1'b0);
        target = item_count + PHASE_ITEMS;
        while (item_count < target) random_grid();
        drain();

        if (error_count == 0 && pending_results == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/gsds_pkg.sv
rtl/gsds_line_bank.sv
rtl/gsds_filter.sv
rtl/grid_scalar_diffusion_stencil_unit.sv
tb/sv/grid_scalar_diffusion_stencil_checker.sv
tb/sv/grid_scalar_diffusion_stencil_unit_test.sv
